>>> hdl/fcsb_pkg.sv
// ----------------------------------------------------------------------------
// fcsb_pkg
// Shared types and constants for the frustum culling unit: function codes,
// plane coefficients, test operands and per-plane result flags.
// ----------------------------------------------------------------------------
package fcsb_pkg;

    // accumulator width: three Q32.32 products plus two scaled Q16.16 terms
    localparam int ACC_W = 68;

    typedef logic signed [31:0]      coord_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    // function codes carried in tuser
    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_SPHERE = 2'd1,
        FUNC_BOX    = 2'd2
    } func_t;

    // one stored frustum plane
    typedef struct packed {
        coord_t nx;
        coord_t ny;
        coord_t nz;
        coord_t d;
    } plane_t;

    // operands of a sphere or box test
    typedef struct packed {
        logic   is_sphere;
        coord_t ax;
        coord_t ay;
        coord_t az;
        coord_t aw;
        coord_t bx;
        coord_t by;
        coord_t bz;
    } test_t;

    // per-plane outcome of one test
    typedef struct packed {
        logic near_pos;
        logic far_nonneg;
    } flags_t;

endpackage

>>> hdl/frustum_cull_sphere_box_unit.sv
// ----------------------------------------------------------------------------
// frustum_cull_sphere_box_unit
// View frustum culling of spheres and axis-aligned boxes against stored planes.
// ----------------------------------------------------------------------------
// stages: input, products, partial sums, signs, output register
// one word per cycle while the output is not held; a load or unused code
// gives no result; the five-stage pipeline has one multiply stage per lane
// reset clears the pipeline valid bits; the plane store is not reset
// ----------------------------------------------------------------------------
module frustum_cull_sphere_box_unit #(
    parameter int PLANE_COUNT = 6,
    parameter int FRAC_BITS   = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // plane_sel[2:0], first_x[34:3], first_y[66:35], first_z[98:67],
    // first_w[130:99], second_x[162:131], second_y[194:163], second_z[226:195]
    input  logic [231:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // culled[0], straddles[1]
    output logic [7:0]   m_axis_tdata
);

    logic en;

    // stage 1: input register
    logic              vld1_reg;
    fcsb_pkg::func_t   func1_reg;
    logic [2:0]        sel1_reg;
    fcsb_pkg::coord_t  ax1_reg, ay1_reg, az1_reg, aw1_reg, bx1_reg, by1_reg, bz1_reg;
    logic              is_test1, is_box1, load_we;
    fcsb_pkg::test_t   test1;
    fcsb_pkg::plane_t  load_plane;

    // plane store
    fcsb_pkg::plane_t  planes_reg [PLANE_COUNT];

    // stages 2 to 4: valid and box flags
    logic vld2_reg, vld3_reg, vld4_reg;
    logic box2_reg, box3_reg, box4_reg;

    // lane outputs
    fcsb_pkg::flags_t  lane_flags [PLANE_COUNT];

    // stage 5: output register
    logic out_vld_reg, culled_reg, strad_reg;
    logic any_near, any_far;

    // the whole pipeline moves unless the output word is held
    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    // input word capture
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && s_axis_tvalid)
        begin
            func1_reg <= fcsb_pkg::func_t'(s_axis_tuser[1:0]);
            sel1_reg  <= s_axis_tdata[2:0];
            ax1_reg   <= s_axis_tdata[34:3];
            ay1_reg   <= s_axis_tdata[66:35];
            az1_reg   <= s_axis_tdata[98:67];
            aw1_reg   <= s_axis_tdata[130:99];
            bx1_reg   <= s_axis_tdata[162:131];
            by1_reg   <= s_axis_tdata[194:163];
            bz1_reg   <= s_axis_tdata[226:195];
        end
    end

    // decode of the stage 1 word
    always_comb
    begin
        is_test1 = 1'b0;
        is_box1  = 1'b0;
        case (func1_reg)
            fcsb_pkg::FUNC_SPHERE: is_test1 = 1'b1;
            fcsb_pkg::FUNC_BOX:
            begin
                is_test1 = 1'b1;
                is_box1  = 1'b1;
            end
            default: is_test1 = 1'b0;
        endcase
        load_we = en && vld1_reg && (func1_reg == fcsb_pkg::FUNC_LOAD)
                  && ({1'b0, sel1_reg} < 4'(PLANE_COUNT));
        test1.is_sphere = (func1_reg == fcsb_pkg::FUNC_SPHERE);
        test1.ax        = ax1_reg;
        test1.ay        = ay1_reg;
        test1.az        = az1_reg;
        test1.aw        = aw1_reg;
        test1.bx        = bx1_reg;
        test1.by        = by1_reg;
        test1.bz        = bz1_reg;
        load_plane.nx   = ax1_reg;
        load_plane.ny   = ay1_reg;
        load_plane.nz   = az1_reg;
        load_plane.d    = aw1_reg;
    end

    // plane write in step with the lanes reading the store
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < PLANE_COUNT; k++)
        begin
            if (load_we && (sel1_reg == 3'(k)))
            begin
                planes_reg[k] <= load_plane;
            end
        end
    end

    // one lane per plane
    for (genvar g = 0; g < PLANE_COUNT; g++)
    begin : g_lane
        fcsb_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk   (clk),
            .en    (en),
            .item  (test1),
            .plane (planes_reg[g]),
            .flags (lane_flags[g])
        );
    end

    // valid bits travel with the lane data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else if (en)
        begin
            vld2_reg <= vld1_reg && is_test1;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            box2_reg <= is_box1;
            box3_reg <= box2_reg;
            box4_reg <= box3_reg;
        end
    end

    // reduce over planes
    always_comb
    begin
        any_near = 1'b0;
        any_far  = 1'b0;
        for (int k = 0; k < PLANE_COUNT; k++)
        begin
            any_near = any_near | lane_flags[k].near_pos;
            any_far  = any_far | lane_flags[k].far_nonneg;
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= vld4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            culled_reg <= any_near;
            strad_reg  <= box4_reg && !any_near && any_far;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {6'b0, strad_reg, culled_reg};

endmodule

>>> hdl/fcsb_lane.sv
// ----------------------------------------------------------------------------
// fcsb_lane
// One plane of the culling pipeline: multiplies, picks near and far corners,
// sums exactly at full width and registers the sign of each distance.
// ----------------------------------------------------------------------------
module fcsb_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic             clk,
    input  logic             en,
    input  fcsb_pkg::test_t  item,
    input  fcsb_pkg::plane_t plane,
    output fcsb_pkg::flags_t flags
);

    // stage 2: products and scaled terms
    logic signed [63:0] pax_reg, pay_reg, paz_reg;
    logic signed [63:0] pbx_reg, pby_reg, pbz_reg;
    logic signed [63:0] pax_next, pay_next, paz_next;
    logic signed [63:0] pbx_next, pby_next, pbz_next;
    fcsb_pkg::acc_t     dterm_reg, rterm_reg, dterm_next, rterm_next;
    logic               gtx_reg, gty_reg, gtz_reg, sphere_reg;

    // stage 3: partial sums
    fcsb_pkg::acc_t nxy_reg, nzd_reg, fxy_reg, fzd_reg;
    fcsb_pkg::acc_t nxy_next, nzd_next, fxy_next, fzd_next;
    fcsb_pkg::acc_t near_x, near_y, near_z, far_x, far_y, far_z;

    // stage 4: full sums and signs
    fcsb_pkg::acc_t   near_sum, far_sum;
    fcsb_pkg::flags_t flags_reg, flags_next;

    // corner products for both box corners
    assign pax_next = $signed(item.ax) * $signed(plane.nx);
    assign pay_next = $signed(item.ay) * $signed(plane.ny);
    assign paz_next = $signed(item.az) * $signed(plane.nz);
    assign pbx_next = $signed(item.bx) * $signed(plane.nx);
    assign pby_next = $signed(item.by) * $signed(plane.ny);
    assign pbz_next = $signed(item.bz) * $signed(plane.nz);

    // offset and radius scaled to Q32.32
    assign dterm_next = fcsb_pkg::acc_t'(plane.d) <<< FRAC_BITS;
    assign rterm_next = item.is_sphere ? (fcsb_pkg::acc_t'(item.aw) <<< FRAC_BITS) : '0;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pax_reg    <= pax_next;
            pay_reg    <= pay_next;
            paz_reg    <= paz_next;
            pbx_reg    <= pbx_next;
            pby_reg    <= pby_next;
            pbz_reg    <= pbz_next;
            dterm_reg  <= dterm_next;
            rterm_reg  <= rterm_next;
            gtx_reg    <= plane.nx > 0;
            gty_reg    <= plane.ny > 0;
            gtz_reg    <= plane.nz > 0;
            sphere_reg <= item.is_sphere;
        end
    end

    // near corner follows min on a positive normal, sphere uses the center
    always_comb
    begin
        near_x   = (sphere_reg || gtx_reg) ? fcsb_pkg::acc_t'(pax_reg) : fcsb_pkg::acc_t'(pbx_reg);
        near_y   = (sphere_reg || gty_reg) ? fcsb_pkg::acc_t'(pay_reg) : fcsb_pkg::acc_t'(pby_reg);
        near_z   = (sphere_reg || gtz_reg) ? fcsb_pkg::acc_t'(paz_reg) : fcsb_pkg::acc_t'(pbz_reg);
        far_x    = gtx_reg ? fcsb_pkg::acc_t'(pbx_reg) : fcsb_pkg::acc_t'(pax_reg);
        far_y    = gty_reg ? fcsb_pkg::acc_t'(pby_reg) : fcsb_pkg::acc_t'(pay_reg);
        far_z    = gtz_reg ? fcsb_pkg::acc_t'(pbz_reg) : fcsb_pkg::acc_t'(paz_reg);
        nxy_next = near_x + near_y;
        nzd_next = near_z + dterm_reg - rterm_reg;
        fxy_next = far_x + far_y;
        fzd_next = far_z + dterm_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nxy_reg <= nxy_next;
            nzd_reg <= nzd_next;
            fxy_reg <= fxy_next;
            fzd_reg <= fzd_next;
        end
    end

    // final sums and their signs
    always_comb
    begin
        near_sum              = nxy_reg + nzd_reg;
        far_sum               = fxy_reg + fzd_reg;
        flags_next.near_pos   = !near_sum[fcsb_pkg::ACC_W-1] && (near_sum != '0);
        flags_next.far_nonneg = !far_sum[fcsb_pkg::ACC_W-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flags_reg <= flags_next;
        end
    end

    assign flags = flags_reg;

endmodule

>>> tb/sv/frustum_cull_sphere_box_unit_checker.sv
// ----------------------------------------------------------------------------
// frustum_cull_sphere_box_unit_checker
// Watches both stream channels of the culling unit. It keeps its own copy of
// the six frustum planes, works out the culled and straddles flags of every
// accepted sphere or box test with exact wide sums, and compares each result
// word in order against the oldest outstanding verdict.
// ----------------------------------------------------------------------------
module frustum_cull_sphere_box_unit_checker #(
    parameter int PLANE_COUNT = 6,
    parameter int FRAC_BITS   = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [231:0] s_axis_tdata,
    input  logic [1:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [7:0]   m_axis_tdata,
    output int           failures,
    output int           pending,
    output int           load_count,
    output int           sphere_count,
    output int           box_count,
    output int           culled_count,
    output int           straddle_count
);

    typedef struct packed {
        logic culled;
        logic straddles;
    } verdict_t;

    fcsb_pkg::plane_t frustum [PLANE_COUNT];
    verdict_t         expected_verdicts [$];

    // sign of n.p + d - lift, formed exactly at full width
    function automatic int plane_sign(fcsb_pkg::plane_t p, fcsb_pkg::coord_t px,
                                      fcsb_pkg::coord_t py, fcsb_pkg::coord_t pz,
                                      fcsb_pkg::coord_t lift);
        logic signed [71:0] wx, wy, wz, wd, qx, qy, qz, ql, sum;
        wx = $signed(p.nx);
        wy = $signed(p.ny);
        wz = $signed(p.nz);
        wd = $signed(p.d);
        qx = px;
        qy = py;
        qz = pz;
        ql = lift;
        sum = wx * qx + wy * qy + wz * qz + (wd <<< FRAC_BITS) - (ql <<< FRAC_BITS);
        if (sum > 0)
            return 1;
        if (sum == 0)
            return 0;
        return -1;
    endfunction

    // sphere is culled when its center lies farther out than the radius
    function automatic verdict_t judge_sphere(fcsb_pkg::coord_t cx, fcsb_pkg::coord_t cy,
                                              fcsb_pkg::coord_t cz,
                                              fcsb_pkg::coord_t radius);
        verdict_t v;
        v = '0;
        for (int k = 0; k < PLANE_COUNT; k++)
        begin
            if (plane_sign(frustum[k], cx, cy, cz, radius) > 0)
                v.culled = 1'b1;
        end
        return v;
    endfunction

    // box: near corner outside culls, far corner on or past a plane straddles
    function automatic verdict_t judge_box(fcsb_pkg::coord_t lx, fcsb_pkg::coord_t ly,
                                           fcsb_pkg::coord_t lz, fcsb_pkg::coord_t hx,
                                           fcsb_pkg::coord_t hy, fcsb_pkg::coord_t hz);
        verdict_t         v;
        fcsb_pkg::coord_t nx, ny, nz, fx, fy, fz;
        v = '0;
        for (int k = 0; k < PLANE_COUNT; k++)
        begin
            if ($signed(frustum[k].nx) > 0)
            begin
                nx = lx;
                fx = hx;
            end
            else
            begin
                nx = hx;
                fx = lx;
            end
            if ($signed(frustum[k].ny) > 0)
            begin
                ny = ly;
                fy = hy;
            end
            else
            begin
                ny = hy;
                fy = ly;
            end
            if ($signed(frustum[k].nz) > 0)
            begin
                nz = lz;
                fz = hz;
            end
            else
            begin
                nz = hz;
                fz = lz;
            end
            if (plane_sign(frustum[k], nx, ny, nz, '0) > 0)
            begin
                v.culled = 1'b1;
                break;
            end
            if (plane_sign(frustum[k], fx, fy, fz, '0) >= 0)
                v.straddles = 1'b1;
        end
        if (v.culled)
            v.straddles = 1'b0;
        return v;
    endfunction

    // result side first, then the word accepted at the same edge
    always @(posedge clk)
    begin : watch
        fcsb_pkg::func_t  fn;
        logic [2:0]       sel;
        fcsb_pkg::coord_t ax, ay, az, aw, bx, by, bz;
        verdict_t         want;
        int               bad;
        if (!rst_n)
        begin
            expected_verdicts.delete();
            failures       <= 0;
            load_count     <= 0;
            sphere_count   <= 0;
            box_count      <= 0;
            culled_count   <= 0;
            straddle_count <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $error("result word 0x%02h with no test outstanding", m_axis_tdata);
                    failures <= failures + 1;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    bad  = 0;
                    if (m_axis_tdata[0] !== want.culled)
                    begin
                        $error("culled: expected %0d, actual %0d", want.culled,
                               m_axis_tdata[0]);
                        bad++;
                    end
                    if (m_axis_tdata[1] !== want.straddles)
                    begin
                        $error("straddles: expected %0d, actual %0d", want.straddles,
                               m_axis_tdata[1]);
                        bad++;
                    end
                    failures       <= failures + bad;
                    culled_count   <= culled_count + want.culled;
                    straddle_count <= straddle_count + want.straddles;
                end
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                fn  = fcsb_pkg::func_t'(s_axis_tuser);
                sel = s_axis_tdata[2:0];
                ax  = s_axis_tdata[34:3];
                ay  = s_axis_tdata[66:35];
                az  = s_axis_tdata[98:67];
                aw  = s_axis_tdata[130:99];
                bx  = s_axis_tdata[162:131];
                by  = s_axis_tdata[194:163];
                bz  = s_axis_tdata[226:195];
                case (fn)
                    fcsb_pkg::FUNC_LOAD:
                    begin
                        // out-of-range slots are dropped by the unit
                        if (sel < PLANE_COUNT)
                        begin
                            frustum[sel] = '{nx: ax, ny: ay, nz: az, d: aw};
                            load_count <= load_count + 1;
                        end
                    end
                    fcsb_pkg::FUNC_SPHERE:
                    begin
                        expected_verdicts.push_back(judge_sphere(ax, ay, az, aw));
                        sphere_count <= sphere_count + 1;
                    end
                    fcsb_pkg::FUNC_BOX:
                    begin
                        expected_verdicts.push_back(judge_box(ax, ay, az, bx, by, bz));
                        box_count <= box_count + 1;
                    end
                    default:
                        ;
                endcase
            end
        end
        pending <= expected_verdicts.size();
    end

endmodule

>>> tb/sv/frustum_cull_sphere_box_unit_test.sv
// ----------------------------------------------------------------------------
// frustum_cull_sphere_box_unit_test
// Drives plane loads, sphere tests and box tests into the culling unit with
// random stalls on both channels; a checker beside the unit predicts every
// result word and counts mismatches, and this top gives the verdict.
// ----------------------------------------------------------------------------
module frustum_cull_sphere_box_unit_test;

    localparam logic [1:0]       FUNC_SPARE = 2'd3;
    localparam fcsb_pkg::coord_t ONE        = 32'sh0001_0000;
    localparam fcsb_pkg::coord_t CMAX       = 32'sh7fff_ffff;
    localparam fcsb_pkg::coord_t CMIN       = 32'sh8000_0000;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [231:0] s_axis_tdata  = '0;
    logic [1:0]   s_axis_tuser  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [7:0]   m_axis_tdata;
    bit           calm          = 1'b0;

    int failures, pending;
    int load_count, sphere_count, box_count, culled_count, straddle_count;

    always #4 clk = ~clk;

    frustum_cull_sphere_box_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    frustum_cull_sphere_box_unit_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .failures       (failures),
        .pending        (pending),
        .load_count     (load_count),
        .sphere_count   (sphere_count),
        .box_count      (box_count),
        .culled_count   (culled_count),
        .straddle_count (straddle_count)
    );

    // result side backpressure
    always @(negedge clk)
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 24);

    // present one word at a falling edge and hold it until accepted
    task automatic send_word(input logic [1:0] fn, input logic [2:0] sel,
                             input fcsb_pkg::coord_t ax, input fcsb_pkg::coord_t ay,
                             input fcsb_pkg::coord_t az, input fcsb_pkg::coord_t aw,
                             input fcsb_pkg::coord_t bx, input fcsb_pkg::coord_t by,
                             input fcsb_pkg::coord_t bz);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 24)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {5'b0, bz, by, bx, aw, az, ay, ax, sel};
        s_axis_tuser  = fn;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // coordinate: whole units, fine values within +/- span, or any word
    function automatic fcsb_pkg::coord_t pick_coord(int span);
        case ($urandom_range(0, 7))
            0:       return fcsb_pkg::coord_t'($urandom);
            1, 2, 3: return fcsb_pkg::coord_t'((int'($urandom_range(0, 2 * span)) - span)
                                               * 65536);
            default: return fcsb_pkg::coord_t'(int'($urandom_range(0, 2 * span * 65536))
                                               - span * 65536);
        endcase
    endfunction

    // normal component: zero, unit, fraction of a unit, or any word
    function automatic fcsb_pkg::coord_t pick_normal();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return $urandom_range(0, 1) ? ONE : -ONE;
            2:       return fcsb_pkg::coord_t'($urandom);
            default: return fcsb_pkg::coord_t'(int'($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    initial
    begin : stimulus
        int               counted;
        int               roll;
        int               wait_cycles;
        fcsb_pkg::coord_t lo [3];
        fcsb_pkg::coord_t hi [3];
        fcsb_pkg::coord_t radius;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // axis-aligned frustum, half size ten, all six slots written first
        send_word(fcsb_pkg::FUNC_LOAD, 3'd0,  ONE,   '0,   '0, -10 * ONE, '0, '0, '0);
        send_word(fcsb_pkg::FUNC_LOAD, 3'd1, -ONE,   '0,   '0, -10 * ONE, '0, '0, '0);
        send_word(fcsb_pkg::FUNC_LOAD, 3'd2,   '0,  ONE,   '0, -10 * ONE, '0, '0, '0);
        send_word(fcsb_pkg::FUNC_LOAD, 3'd3,   '0, -ONE,   '0, -10 * ONE, '0, '0, '0);
        send_word(fcsb_pkg::FUNC_LOAD, 3'd4,   '0,   '0,  ONE, -10 * ONE, '0, '0, '0);
        send_word(fcsb_pkg::FUNC_LOAD, 3'd5,   '0,   '0, -ONE, -10 * ONE, '0, '0, '0);

        // slots past the end and the spare code change nothing
        send_word(fcsb_pkg::FUNC_LOAD, 3'd6, -1, -1, -1, -1, -1, -1, -1);
        send_word(fcsb_pkg::FUNC_LOAD, 3'd7, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX);
        send_word(FUNC_SPARE, 3'd7, -1, -1, -1, -1, -1, -1, -1);

        // spheres: inside, outside, exactly touching, negative radius, extremes
        send_word(fcsb_pkg::FUNC_SPHERE, 3'd0, '0, '0, '0, ONE, '0, '0, '0);
        send_word(fcsb_pkg::FUNC_SPHERE, 3'd0, 20 * ONE, '0, '0, ONE, '0, '0, '0);
        send_word(fcsb_pkg::FUNC_SPHERE, 3'd0, 11 * ONE, '0, '0, ONE, '0, '0, '0);
        send_word(fcsb_pkg::FUNC_SPHERE, 3'd0, '0, '0, -10 * ONE, -ONE, '0, '0, '0);
        send_word(fcsb_pkg::FUNC_SPHERE, 3'd0, CMAX, CMIN, CMAX, CMAX, '0, '0, '0);
        send_word(fcsb_pkg::FUNC_SPHERE, 3'd0, CMIN, CMIN, CMIN, CMIN, '0, '0, '0);

        // boxes: inside, outside, straddling, far corner on the plane, odd shapes
        send_word(fcsb_pkg::FUNC_BOX, 3'd0, -ONE, -ONE, -ONE, '0, ONE, ONE, ONE);
        send_word(fcsb_pkg::FUNC_BOX, 3'd0, 12 * ONE, '0, '0, '0, 15 * ONE, ONE, ONE);
        send_word(fcsb_pkg::FUNC_BOX, 3'd0, 5 * ONE, '0, '0, '0, 15 * ONE, ONE, ONE);
        send_word(fcsb_pkg::FUNC_BOX, 3'd0, '0, '0, '0, '0, 10 * ONE, ONE, ONE);
        send_word(fcsb_pkg::FUNC_BOX, 3'd0, 5 * ONE, 5 * ONE, 5 * ONE, '0, -5 * ONE,
                  -5 * ONE, -5 * ONE);
        send_word(fcsb_pkg::FUNC_BOX, 3'd0, CMIN, CMIN, CMIN, -1, CMAX, CMAX, CMAX);

        // plane with extreme coefficients and a zero component
        send_word(fcsb_pkg::FUNC_LOAD, 3'd2, CMAX, CMIN, '0, CMIN, '0, '0, '0);
        send_word(fcsb_pkg::FUNC_SPHERE, 3'd0, CMIN, CMAX, CMAX, CMIN, '0, '0, '0);
        send_word(fcsb_pkg::FUNC_BOX, 3'd0, CMIN, CMIN, CMIN, '0, CMAX, CMAX, CMAX);
        send_word(fcsb_pkg::FUNC_BOX, 3'd0, CMAX, CMAX, '0, '0, CMIN, CMIN, '0);

        // random part with a long stretch of no stalls in the middle
        counted = 0;
        while (counted < 500)
        begin
            calm = (counted >= 200 && counted < 320);
            roll = $urandom_range(0, 99);
            if (roll < 10)
            begin
                send_word(fcsb_pkg::FUNC_LOAD, 3'($urandom_range(0, 5)), pick_normal(),
                          pick_normal(), pick_normal(), pick_coord(40),
                          fcsb_pkg::coord_t'($urandom), fcsb_pkg::coord_t'($urandom),
                          fcsb_pkg::coord_t'($urandom));
                counted++;
            end
            else if (roll < 14)
            begin
                if ($urandom_range(0, 1))
                    send_word(fcsb_pkg::FUNC_LOAD, 3'(6 + $urandom_range(0, 1)),
                              fcsb_pkg::coord_t'($urandom), fcsb_pkg::coord_t'($urandom),
                              fcsb_pkg::coord_t'($urandom), fcsb_pkg::coord_t'($urandom),
                              '0, '0, '0);
                else
                    send_word(FUNC_SPARE, 3'($urandom_range(0, 7)),
                              fcsb_pkg::coord_t'($urandom), fcsb_pkg::coord_t'($urandom),
                              fcsb_pkg::coord_t'($urandom), fcsb_pkg::coord_t'($urandom),
                              fcsb_pkg::coord_t'($urandom), fcsb_pkg::coord_t'($urandom),
                              fcsb_pkg::coord_t'($urandom));
            end
            else if (roll < 57)
            begin
                radius = ($urandom_range(0, 7) == 0)
                         ? fcsb_pkg::coord_t'($urandom)
                         : fcsb_pkg::coord_t'($urandom_range(0, 10 * 65536));
                send_word(fcsb_pkg::FUNC_SPHERE, 3'($urandom_range(0, 7)), pick_coord(30),
                          pick_coord(30), pick_coord(30), radius,
                          fcsb_pkg::coord_t'($urandom), fcsb_pkg::coord_t'($urandom),
                          fcsb_pkg::coord_t'($urandom));
                counted++;
            end
            else
            begin
                // mostly well-formed boxes, now and then an unrelated max corner
                for (int k = 0; k < 3; k++)
                begin
                    lo[k] = pick_coord(30);
                    if ($urandom_range(0, 7) == 0)
                        hi[k] = fcsb_pkg::coord_t'($urandom);
                    else
                        hi[k] = lo[k] + fcsb_pkg::coord_t'($urandom_range(0, 20 * 65536));
                end
                send_word(fcsb_pkg::FUNC_BOX, 3'($urandom_range(0, 7)), lo[0], lo[1], lo[2],
                          fcsb_pkg::coord_t'($urandom), hi[0], hi[1], hi[2]);
                counted++;
            end
        end
        calm = 1'b0;
        @(negedge clk);
        s_axis_tvalid = 1'b0;

        // drain, then wait on past the pipeline depth
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (pending != 0)
            $error("%0d results never arrived", pending);

        $display("covered %0d plane loads, %0d sphere tests and %0d box tests",
                 load_count, sphere_count, box_count);
        $display("%0d results culled and %0d straddling, with stalls on both channels",
                 culled_count, straddle_count);
        if (failures == 0 && pending == 0)
            $display("frustum_cull_sphere_box_unit: match");
        else
            $display("frustum_cull_sphere_box_unit: mismatch");
        $finish;
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("frustum_cull_sphere_box_unit: mismatch");
        $finish;
    end

endmodule
